// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL modules.
// Each expects clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication violated");

// Next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`endif

// ===== hw/rtl/taq_pkg.sv =====
package taq_pkg;

  // Width of the node index fields on the ports
  localparam int unsigned NODE_W = 6;

  // Item kinds
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LDWR,
    ST_READ,
    ST_EVAL,
    ST_DONE
  } taq_state_t;

  // Finished result handed from the controller to the output register
  typedef struct packed {
    logic valid;
    logic path_found;
    logic bad_index;
    logic matrix_full;
  } taq_res_t;

endpackage

// ===== hw/rtl/taq_colmem.sv =====
module taq_colmem import taq_pkg::*; #(
  parameter int unsigned NODES = 16,
  localparam int unsigned IdxW = $clog2(NODES)
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [IdxW-1:0]  rd_addr,
  output logic [NODES-1:0] rd_data_r,
  input  logic             wr_en,
  input  logic [IdxW-1:0]  wr_addr,
  input  logic [NODES-1:0] wr_data
);

  // One word per column: bit r of word c is the edge r -> c
  logic [NODES-1:0] mem_r [NODES];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/taq_ctrl.sv =====
`include "assert_macros.svh"

module taq_ctrl import taq_pkg::*; #(
  parameter int unsigned NODES = 16,
  localparam int unsigned IdxW = $clog2(NODES)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_kind,
  input  logic              in_cell_bit,
  input  logic [NODE_W-1:0] in_from_node,
  input  logic [NODE_W-1:0] in_to_node,
  output logic              mem_rd_en,
  output logic [IdxW-1:0]   mem_rd_addr,
  input  logic [NODES-1:0]  mem_rd_data,
  output logic              mem_wr_en,
  output logic [IdxW-1:0]   mem_wr_addr,
  output logic [NODES-1:0]  mem_wr_data,
  output taq_res_t          res,
  input  logic              res_take
);

  localparam logic [IdxW-1:0]   LastIdx = IdxW'(NODES - 1);
  localparam logic [NODE_W:0]   NodeLim = (NODE_W + 1)'(NODES);

  taq_state_t       state_r, state_nxt;
  logic [IdxW-1:0]  row_r, row_nxt;
  logic [IdxW-1:0]  col_r, col_nxt;
  logic             full_r, full_nxt;
  logic [IdxW-1:0]  cur_r, cur_nxt;
  logic [IdxW-1:0]  step_r, step_nxt;
  logic [IdxW-1:0]  from_r, from_nxt;
  logic             bit_r, bit_nxt;
  logic             found_r, found_nxt;
  logic             bad_r, bad_nxt;

  logic             query_bad;
  logic [NODES-1:0] row_lt;
  logic [NODES-1:0] col_vis;
  logic [NODES-1:0] lowest;
  logic [NODES-1:0] ld_data;
  logic [IdxW-1:0]  pred;
  logic             no_pred;
  logic             cell_hit;

  // Flag node indices outside the matrix
  assign query_bad = ({1'b0, in_from_node} >= NodeLim) || ({1'b0, in_to_node} >= NodeLim);

  // Rows already loaded; cells past the fill point read as zero
  always_comb begin
    for (int r = 0; r < NODES; r++) begin
      row_lt[r]  = IdxW'(r) < row_r;
      col_vis[r] = full_r || row_lt[r] || ((IdxW'(r) == row_r) && (cur_r < col_r));
    end
  end

  // Lowest predecessor: isolate the lowest set bit, then encode it
  always_comb begin
    logic [NODES-1:0] col_q;
    col_q   = mem_rd_data & col_vis;
    lowest  = col_q & (~col_q + NODES'(1));
    no_pred = (col_q == '0);
    cell_hit = col_q[from_r];
    pred    = '0;
    for (int i = 0; i < NODES; i++) begin
      if (lowest[i]) begin
        pred = pred | IdxW'(i);
      end
    end
  end

  // Merge the new cell into the loaded part of its column
  always_comb begin
    ld_data         = mem_rd_data & row_lt;
    ld_data[row_r]  = bit_r;
  end

  // State and counter registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      row_r   <= '0;
      col_r   <= '0;
      full_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      full_r  <= full_nxt;
    end
  end

  // Walk and word registers
  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    step_r  <= step_nxt;
    from_r  <= from_nxt;
    bit_r   <= bit_nxt;
    found_r <= found_nxt;
    bad_r   <= bad_nxt;
  end

  // Next state and memory control
  always_comb begin
    state_nxt   = state_r;
    row_nxt     = row_r;
    col_nxt     = col_r;
    full_nxt    = full_r;
    cur_nxt     = cur_r;
    step_nxt    = step_r;
    from_nxt    = from_r;
    bit_nxt     = bit_r;
    found_nxt   = found_r;
    bad_nxt     = bad_r;
    mem_rd_en   = 1'b0;
    mem_rd_addr = col_r;
    mem_wr_en   = 1'b0;
    mem_wr_addr = col_r;
    mem_wr_data = ld_data;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          bit_nxt   = in_cell_bit;
          found_nxt = 1'b0;
          bad_nxt   = 1'b0;
          if (in_kind == KIND_LOAD) begin
            if (full_r) begin
              state_nxt = ST_DONE;
            end else begin
              mem_rd_en = 1'b1;
              state_nxt = ST_LDWR;
            end
          end else if (query_bad) begin
            bad_nxt   = 1'b1;
            state_nxt = ST_DONE;
          end else begin
            cur_nxt   = in_to_node[IdxW-1:0];
            from_nxt  = in_from_node[IdxW-1:0];
            step_nxt  = '0;
            state_nxt = ST_READ;
          end
        end
      end

      ST_LDWR: begin
        // Write back the column and advance the fill point
        mem_wr_en = 1'b1;
        if (col_r == LastIdx) begin
          col_nxt = '0;
          if (row_r == LastIdx) begin
            full_nxt = 1'b1;
          end else begin
            row_nxt = row_r + 1'b1;
          end
        end else begin
          col_nxt = col_r + 1'b1;
        end
        state_nxt = ST_DONE;
      end

      ST_READ: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = cur_r;
        state_nxt   = ST_EVAL;
      end

      ST_EVAL: begin
        priority if (cur_r == from_r) begin
          found_nxt = 1'b1;
          state_nxt = ST_DONE;
        end else if (cell_hit) begin
          found_nxt = 1'b1;
          state_nxt = ST_DONE;
        end else if (no_pred || (step_r == LastIdx)) begin
          state_nxt = ST_DONE;
        end else begin
          cur_nxt   = pred;
          step_nxt  = step_r + 1'b1;
          state_nxt = ST_READ;
        end
      end

      ST_DONE: begin
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_stall        = (state_r != ST_IDLE);
  assign res.valid       = (state_r == ST_DONE);
  assign res.path_found  = found_r;
  assign res.bad_index   = bad_r;
  assign res.matrix_full = full_r;

  `ASSERT_IMPL(a_wr_only_unfull, mem_wr_en, !full_r && (state_r == ST_LDWR))
  `ASSERT_NEXT(a_full_sticky, full_r, full_r)
  `ASSERT_IMPL(a_res_excl, res.valid, !(found_r && bad_r))
  `ASSERT_NEXT(a_take_to_idle, res.valid && res_take, state_r == ST_IDLE)

endmodule

// ===== hw/rtl/tree_ancestor_query.sv =====
// Channel | Handshake          | Word fields
// in_     | in_valid/in_stall  | kind, cell_bit, from_node, to_node
// out_    | out_valid/out_stall| path_found, bad_index, matrix_full
//
// A load reads its column and writes it back before the result; an ignored
// load or a bad query goes straight to the result. A query walks back over
// predecessors; each step is one column read of the matrix memory plus a
// priority encode. After reset the matrix needs no clearing pass: the fill
// counters make unloaded cells read as zero.
// The output register lets the next word in while a result waits.
module tree_ancestor_query import taq_pkg::*; #(
  parameter int unsigned NODES = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_kind,
  input  logic              in_cell_bit,
  input  logic [NODE_W-1:0] in_from_node,
  input  logic [NODE_W-1:0] in_to_node,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_path_found,
  output logic              out_bad_index,
  output logic              out_matrix_full
);

  localparam int unsigned IdxW = $clog2(NODES);

  logic             mem_rd_en;
  logic [IdxW-1:0]  mem_rd_addr;
  logic [NODES-1:0] mem_rd_data;
  logic             mem_wr_en;
  logic [IdxW-1:0]  mem_wr_addr;
  logic [NODES-1:0] mem_wr_data;
  taq_res_t         res;
  logic             res_take;

  logic             out_valid_r, out_valid_nxt;
  logic             found_r, bad_r, full_r;

  taq_ctrl #(.NODES(NODES)) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_kind      (in_kind),
    .in_cell_bit  (in_cell_bit),
    .in_from_node (in_from_node),
    .in_to_node   (in_to_node),
    .mem_rd_en    (mem_rd_en),
    .mem_rd_addr  (mem_rd_addr),
    .mem_rd_data  (mem_rd_data),
    .mem_wr_en    (mem_wr_en),
    .mem_wr_addr  (mem_wr_addr),
    .mem_wr_data  (mem_wr_data),
    .res          (res),
    .res_take     (res_take)
  );

  taq_colmem #(.NODES(NODES)) u_colmem (
    .clk       (clk),
    .rd_en     (mem_rd_en),
    .rd_addr   (mem_rd_addr),
    .rd_data_r (mem_rd_data),
    .wr_en     (mem_wr_en),
    .wr_addr   (mem_wr_addr),
    .wr_data   (mem_wr_data)
  );

  // Take a result when the output register is empty or draining
  assign res_take      = res.valid && (!out_valid_r || !out_stall);
  assign out_valid_nxt = res_take || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the result word until it is taken
  always_ff @(posedge clk) begin
    if (res_take) begin
      found_r <= res.path_found;
      bad_r   <= res.bad_index;
      full_r  <= res.matrix_full;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_path_found  = found_r;
  assign out_bad_index   = bad_r;
  assign out_matrix_full = full_r;

endmodule
